// File: src/hfc_pkg.sv
// ----------------------------------------------------------------------------
// HMI frame CRC checker package
// Item types, status codes and frame constants shared by the checker modules.
// ----------------------------------------------------------------------------
package hfc_pkg;

  localparam int unsigned FRAME_LEN_W = 11;
  localparam int unsigned STATUS_W    = 3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HEADER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_TAIL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CRC_ERROR  = 3'd4;

  // CRC-16/MODBUS: reflected polynomial, all-ones start value, no final xor.
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Frame delimiters: "ST<" opens a frame and ">ET" closes its body.
  localparam logic [7:0] HEAD_S  = 8'h53;
  localparam logic [7:0] HEAD_T  = 8'h54;
  localparam logic [7:0] HEAD_LT = 8'h3C;
  localparam logic [7:0] TAIL_GT = 8'h3E;
  localparam logic [7:0] TAIL_E  = 8'h45;
  localparam logic [7:0] TAIL_T  = 8'h54;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [7:0]             command;
    logic [FRAME_LEN_W-1:0] frame_length;
  } out_item_t;

  // Expected header character at a given offset within the header.
  function automatic logic [7:0] header_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = HEAD_S;
      2'd1:    ch = HEAD_T;
      2'd2:    ch = HEAD_LT;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: src/hfc_crc16_byte.sv
// ----------------------------------------------------------------------------
// HMI frame CRC byte update
// Folds one byte into a CRC-16/MODBUS value, all eight bit steps in combinational logic.
// ----------------------------------------------------------------------------
module hfc_crc16_byte (
  input  logic [15:0] crc_cur,
  input  logic [7:0]  data,
  output logic [15:0] crc_upd
);

  always_comb begin
    logic [15:0] c;
    c = crc_cur ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ hfc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_upd = c;
  end

endmodule

// File: src/hfc_frame_fsm.sv
// ----------------------------------------------------------------------------
// HMI frame parser
// Tracks header, tail search and CRC bytes of one buffer and registers the
// verdict when the last byte of the buffer goes through.
// ----------------------------------------------------------------------------
module hfc_frame_fsm #(
  parameter int unsigned MAX_BUFFER = 1024,
  parameter int unsigned MIN_LENGTH = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  hfc_pkg::in_item_t  item,
  output logic               item_ready,
  output logic               result_valid,
  input  logic               result_ready,
  output hfc_pkg::out_item_t result_item
);

  localparam int unsigned CW     = $clog2(MAX_BUFFER + 1);
  localparam int unsigned LW_RAW = $clog2(MAX_BUFFER + 3);
  localparam int unsigned LW     = (LW_RAW > hfc_pkg::FRAME_LEN_W) ? LW_RAW
                                                                   : hfc_pkg::FRAME_LEN_W;

  localparam logic [1:0] TM_NONE = 2'd0;
  localparam logic [1:0] TM_GT   = 2'd1;
  localparam logic [1:0] TM_GTE  = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SEARCH,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_DONE,
    PH_BAD
  } phase_t;

  phase_t                      phase, phase_next;
  logic [CW-1:0]               byte_count, byte_count_next;
  logic [15:0]                 crc_value, crc_value_next;
  logic [1:0]                  tail_match, tail_match_next;
  logic [7:0]                  command_hold, command_hold_next;
  logic [7:0]                  crc_high_hold, crc_high_hold_next;
  logic [hfc_pkg::STATUS_W-1:0] verdict_hold, verdict_hold_next;
  logic [LW-1:0]               length_hold, length_hold_next;

  logic [15:0]        crc_cur;
  logic [15:0]        crc_upd;
  logic               take;
  hfc_pkg::out_item_t result_next;

  // A buffer that starts with this byte begins from the reset CRC.
  assign crc_cur = item.first_byte ? hfc_pkg::CRC_INIT : crc_value;

  hfc_crc16_byte u_crc (
    .crc_cur (crc_cur),
    .data    (item.data_byte),
    .crc_upd (crc_upd)
  );

  assign item_ready = !item.last_byte || !result_valid || result_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    logic       scan;
    logic [7:0] b;
    b    = item.data_byte;
    scan = 1'b0;

    if (item.first_byte) begin
      phase_next         = PH_HEADER;
      byte_count_next    = '0;
      tail_match_next    = TM_NONE;
      command_hold_next  = '0;
      crc_high_hold_next = '0;
      verdict_hold_next  = hfc_pkg::ST_OK;
      length_hold_next   = '0;
    end else begin
      phase_next         = phase;
      byte_count_next    = byte_count;
      tail_match_next    = tail_match;
      command_hold_next  = command_hold;
      crc_high_hold_next = crc_high_hold;
      verdict_hold_next  = verdict_hold;
      length_hold_next   = length_hold;
    end
    crc_value_next = crc_cur;

    // Bytes beyond the buffer limit only count for their last-byte flag.
    if (byte_count_next < CW'(MAX_BUFFER)) begin
      if (byte_count_next == CW'(3)) begin
        command_hold_next = b;
      end
      unique case (phase_next)
        PH_HEADER: begin
          if (b != hfc_pkg::header_char(byte_count_next[1:0])) begin
            phase_next = PH_BAD;
          end else begin
            scan = 1'b1;
            if (byte_count_next == CW'(2)) begin
              phase_next = PH_SEARCH;
            end
          end
        end
        PH_SEARCH: begin
          scan = 1'b1;
        end
        PH_CRC_HI: begin
          crc_high_hold_next = b;
          phase_next         = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          verdict_hold_next = ({crc_high_hold_next, b} == crc_value_next) ?
                              hfc_pkg::ST_OK : hfc_pkg::ST_CRC_ERROR;
          phase_next        = PH_DONE;
        end
        default: begin
        end
      endcase

      if (scan) begin
        crc_value_next = crc_upd;
        if (b == hfc_pkg::TAIL_GT) begin
          tail_match_next = TM_GT;
        end else if (b == hfc_pkg::TAIL_E && tail_match_next == TM_GT) begin
          tail_match_next = TM_GTE;
        end else if (b == hfc_pkg::TAIL_T && tail_match_next == TM_GTE) begin
          tail_match_next  = TM_NONE;
          length_hold_next = LW'(byte_count_next) + LW'(3);
          phase_next       = PH_CRC_HI;
        end else begin
          tail_match_next = TM_NONE;
        end
      end
      byte_count_next = byte_count_next + CW'(1);
    end

    result_next.command      = command_hold_next;
    result_next.frame_length = '0;
    if (32'(byte_count_next) < 32'(MIN_LENGTH)) begin
      result_next.status = hfc_pkg::ST_TOO_SHORT;
    end else if (phase_next == PH_BAD || phase_next == PH_HEADER) begin
      result_next.status = hfc_pkg::ST_BAD_HEADER;
    end else if (phase_next != PH_DONE) begin
      result_next.status = hfc_pkg::ST_NO_TAIL;
    end else begin
      result_next.status       = verdict_hold_next;
      result_next.frame_length = length_hold_next[hfc_pkg::FRAME_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_count    <= '0;
      crc_value     <= hfc_pkg::CRC_INIT;
      tail_match    <= TM_NONE;
      command_hold  <= '0;
      crc_high_hold <= '0;
      verdict_hold  <= hfc_pkg::ST_OK;
      length_hold   <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (take && item.last_byte) begin
        // The buffer is finished: back to the reset state for the next one.
        phase         <= PH_HEADER;
        byte_count    <= '0;
        crc_value     <= hfc_pkg::CRC_INIT;
        tail_match    <= TM_NONE;
        command_hold  <= '0;
        crc_high_hold <= '0;
        verdict_hold  <= hfc_pkg::ST_OK;
        length_hold   <= '0;
        result_valid  <= 1'b1;
        result_item   <= result_next;
      end else begin
        if (take) begin
          phase         <= phase_next;
          byte_count    <= byte_count_next;
          crc_value     <= crc_value_next;
          tail_match    <= tail_match_next;
          command_hold  <= command_hold_next;
          crc_high_hold <= crc_high_hold_next;
          verdict_hold  <= verdict_hold_next;
          length_hold   <= length_hold_next;
        end
        if (result_ready) begin
          result_valid <= 1'b0;
        end
      end
    end
  end

endmodule

// File: src/hmi_frame_crc_checker_top.sv
// ----------------------------------------------------------------------------
// HMI frame CRC checker
// Streams the bytes of a received buffer, checks the "ST<" header, finds the
// ">ET" tail and verifies the CRC-16/MODBUS that follows it.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Item        Moves
//   -------   ------------------------   ---------   ----------------------------
//   byte      byte_valid / byte_ready     in_item_t   data_byte, first/last flags
//   result    result_valid/result_ready   out_item_t  status, command, frame_length
//
// One byte item is accepted in every clock cycle while no stalled result holds
// back a buffer's last byte; the CRC update for a whole byte is unrolled into
// combinational logic behind the input register. The result item of a buffer
// is registered as the parser takes the buffer's last byte from that register.
// Reset is synchronous and leaves the checker waiting for the first byte of
// a buffer, with no result pending. A stalled result only holds back a byte
// that itself ends a buffer; other bytes keep flowing past it.
//
module hmi_frame_crc_checker_top #(
  parameter int unsigned MAX_BUFFER = 1024,
  parameter int unsigned MIN_LENGTH = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  hfc_pkg::in_item_t  byte_item,
  output logic               result_valid,
  input  logic               result_ready,
  output hfc_pkg::out_item_t result_item
);

  // Input register: holds one byte item in front of the parser.
  logic              in_valid;
  hfc_pkg::in_item_t in_item;
  logic              parse_ready;

  // The register is free when empty or when the parser takes its item now,
  // so a new byte can enter in the same cycle the previous one moves on.
  assign byte_ready = !in_valid || parse_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        in_valid <= 1'b1;
        in_item  <= byte_item;
      end else if (parse_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // The parser holds the frame state and the result register.
  hfc_frame_fsm #(
    .MAX_BUFFER (MAX_BUFFER),
    .MIN_LENGTH (MIN_LENGTH)
  ) u_fsm (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (in_valid),
    .item         (in_item),
    .item_ready   (parse_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  // The status code is always one of the five defined verdicts.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.status <= hfc_pkg::ST_CRC_ERROR)
    else $error("result status out of range");

  // Only a frame that reached its CRC bytes reports a length.
  a_length_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.status != hfc_pkg::ST_OK &&
    result_item.status != hfc_pkg::ST_CRC_ERROR |-> result_item.frame_length == '0)
    else $error("frame length given for a failed frame");

  // A byte held back by a stalled result stays in the input register.
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    in_valid && !parse_ready |=> in_valid)
    else $error("byte item lost while the parser was stalled");

  // No result is pending straight after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid)
    else $error("result pending after reset");

endmodule
